### rtl/kdar_pkg.sv
// Shared types and constants for the key debounce / auto-repeat block.
// No dependencies; imported by kdar_key and key_debounce_auto_repeat.
package kdar_pkg;

    localparam int NUM_KEYS_DEF    = 5;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int KEY_FIELD_W = 5;
    localparam int EVENT_W     = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    // register reset values
    localparam logic [CFG_W-1:0]       DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0]       HOLD_RST     = 16'd1000;
    localparam logic [CFG_W-1:0]       LIMIT_RST    = 16'd250;
    localparam logic [KEY_FIELD_W-1:0] REP_MASK_RST = 5'd3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_HOLD     = 3'd1,
        CFG_LIMIT    = 3'd2,
        CFG_REP_MASK = 3'd3
    } t_cfg_idx;

    // timing settings shared by every key
    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] hold;
        logic [CFG_W-1:0] limit;
    } t_key_cfg;

    // per-key controls for one tick
    typedef struct packed {
        logic step;      // a tick is processed this cycle
        logic released;  // key level is high
        logic rep_en;    // auto-repeat enabled
    } t_key_ctl;

endpackage

### rtl/kdar_key.sv
// One key's lock, press counter and repeat counter, stepped once per tick.
// Depends on kdar_pkg for the settings and control structs.
module kdar_key
    import kdar_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_key_cfg i_cfg,
    input  t_key_ctl i_ctl,
    output logic     o_fire
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic                   r_locked, n_locked;
    logic [COUNT_WIDTH-1:0] r_press, n_press;
    logic [COUNT_WIDTH-1:0] r_repeat, n_repeat;
    logic [COUNT_WIDTH-1:0] press_inc, repeat_inc;
    logic                   fire;

    // saturate at all ones
    assign press_inc  = (&r_press)  ? r_press  : r_press + 1'b1;
    assign repeat_inc = (&r_repeat) ? r_repeat : r_repeat + 1'b1;

    always_comb begin
        n_locked = r_locked;
        n_press  = r_press;
        n_repeat = r_repeat;
        fire     = 1'b0;
        if (i_ctl.released) begin
            n_locked = 1'b0;
            n_press  = '0;
            n_repeat = '0;
        end else if (!r_locked) begin
            n_press = press_inc;
            if (CMP_W'(press_inc) >= CMP_W'(i_cfg.debounce)) begin
                n_locked = 1'b1;
                n_press  = '0;
                fire     = 1'b1;
            end
        end else if (i_ctl.rep_en) begin
            if (CMP_W'(r_press) < CMP_W'(i_cfg.hold)) begin
                n_press = press_inc;
            end else if (CMP_W'(repeat_inc) > CMP_W'(i_cfg.limit)) begin
                n_repeat = '0;
                fire     = 1'b1;
            end else begin
                n_repeat = repeat_inc;
            end
        end
    end

    assign o_fire = i_ctl.step & fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_press  <= '0;
            r_repeat <= '0;
        end else if (i_ctl.step) begin
            r_locked <= n_locked;
            r_press  <= n_press;
            r_repeat <= n_repeat;
        end
    end

endmodule

### rtl/key_debounce_auto_repeat.sv
// Key debouncer with auto-repeat, one tick beat in, one event beat out.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle if i_ready allows; per-key update is a single pass.
// Reset (synchronous, active low): locks and counters clear, registers
// return to 20 / 1000 / 250 / 3, both pipeline stages empty.
// Depends on kdar_pkg and kdar_key.
module key_debounce_auto_repeat
    import kdar_pkg::*;
#(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [KEY_FIELD_W-1:0] i_key_levels,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [EVENT_W-1:0]     o_key_event,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_key_cfg               r_cfg;
    logic [KEY_FIELD_W-1:0] r_rep_mask;

    logic                   r_in_valid;
    logic [KEY_FIELD_W-1:0] r_levels;
    logic                   r_out_valid;
    logic [EVENT_W-1:0]     r_event, n_event;

    logic                   out_free;
    logic                   step;
    logic [NUM_KEYS-1:0]    fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= DEBOUNCE_RST;
            r_cfg.hold     <= HOLD_RST;
            r_cfg.limit    <= LIMIT_RST;
            r_rep_mask     <= REP_MASK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_data;
                CFG_HOLD:     r_cfg.hold     <= i_cfg_data;
                CFG_LIMIT:    r_cfg.limit    <= i_cfg_data;
                CFG_REP_MASK: r_rep_mask     <= i_cfg_data[KEY_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_levels <= i_key_levels;
        end
        if (step) begin
            r_event <= n_event;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        t_key_ctl ctl;
        if (k < KEY_FIELD_W) begin : g_field
            assign ctl.released = r_levels[k];
            assign ctl.rep_en   = r_rep_mask[k];
        end else begin : g_extra
            // keys beyond the field read as held down, no repeat
            assign ctl.released = 1'b0;
            assign ctl.rep_en   = 1'b0;
        end
        assign ctl.step = step;

        kdar_key #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_key (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cfg  (r_cfg),
            .i_ctl  (ctl),
            .o_fire (fire[k])
        );
    end

    // highest-numbered firing key wins
    always_comb begin
        n_event = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (fire[k]) begin
                n_event = EVENT_W'(k + 1);
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_key_event = r_event;

    // no key reports unless a tick is actually being processed
    a_fire_needs_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |-> (fire == '0))
        else $error("key fired without a tick step");

    // a stalled input register keeps its tick
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_levels)))
        else $error("input stage lost a stalled tick");

    // a processed tick always lands in the result register
    a_step_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed tick missing from result stage");

    // reported key number stays within the key count when that count fits the event field
    a_event_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (NUM_KEYS > 7 || o_key_event <= EVENT_W'(NUM_KEYS)))
        else $error("key event out of range");

endmodule

### verif/key_debounce_auto_repeat_tb.sv
// Self-checking testbench for key_debounce_auto_repeat: tick beats with random key levels,
// per-tick event prediction, in-order comparison of event beats.
// Depends on kdar_pkg and the key_debounce_auto_repeat RTL.
`timescale 1ns / 1ps

module key_debounce_auto_repeat_tb;
    import kdar_pkg::*;

    localparam int KEYS     = NUM_KEYS_DEF;
    localparam int CW       = COUNT_WIDTH_DEF;
    localparam int IDLE_PCT = 7;
    localparam int MAX_LOGS = 50;
    // indexes from here up select no register
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_BASE = 3'd4;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic [KEY_FIELD_W-1:0] i_key_levels = '1;
    logic                   i_ready      = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index  = '0;
    logic [CFG_W-1:0]       i_cfg_data   = '0;
    logic                   o_ready;
    logic                   o_valid;
    logic [EVENT_W-1:0]     o_key_event;
    logic                   o_cfg_ready;

    // expected key state and register copies
    logic                   held_lock [KEYS];
    logic [CW-1:0]          press_cnt [KEYS];
    logic [CW-1:0]          rep_cnt   [KEYS];
    logic [CFG_W-1:0]       want_debounce = DEBOUNCE_RST;
    logic [CFG_W-1:0]       want_hold     = HOLD_RST;
    logic [CFG_W-1:0]       want_limit    = LIMIT_RST;
    logic [KEY_FIELD_W-1:0] want_rep_mask = REP_MASK_RST;

    logic [KEY_FIELD_W-1:0] level_q [$];
    logic [EVENT_W-1:0]     event_q [$];
    int                     ticks_queued  = 0;
    int                     tick_accepts  = 0;
    int                     err_count     = 0;
    int                     stall_request = 0;
    int                     stall_left    = 0;
    logic                   tick_taken    = 1'b0;
    logic                   steady_run    = 1'b0;

    key_debounce_auto_repeat dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key_levels (i_key_levels),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_key_event  (o_key_event),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(6_000_000);
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (err_count < MAX_LOGS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // advance every key by one tick; the highest reporting key wins
    function automatic logic [EVENT_W-1:0] tick_event(input logic [KEY_FIELD_W-1:0] levels);
        logic [EVENT_W-1:0] ev;
        ev = '0;
        for (int k = 0; k < KEYS; k++) begin
            if (levels[k]) begin
                held_lock[k] = 1'b0;
                press_cnt[k] = '0;
                rep_cnt[k]   = '0;
            end else if (!held_lock[k]) begin
                press_cnt[k] = bump(press_cnt[k]);
                if (press_cnt[k] >= want_debounce) begin
                    held_lock[k] = 1'b1;
                    press_cnt[k] = '0;
                    ev = EVENT_W'(k + 1);
                end
            end else if (want_rep_mask[k]) begin
                if (press_cnt[k] < want_hold) begin
                    press_cnt[k] = bump(press_cnt[k]);
                end else begin
                    rep_cnt[k] = bump(rep_cnt[k]);
                    if (rep_cnt[k] > want_limit) begin
                        rep_cnt[k] = '0;
                        ev = EVENT_W'(k + 1);
                    end
                end
            end
        end
        return ev;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE: want_debounce = data;
            CFG_HOLD:     want_hold     = data;
            CFG_LIMIT:    want_limit    = data;
            CFG_REP_MASK: want_rep_mask = data[KEY_FIELD_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void offer(input logic [KEY_FIELD_W-1:0] lv);
        level_q.push_back(lv);
        ticks_queued++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hld,
                              input logic [CFG_W-1:0] lim, input logic [KEY_FIELD_W-1:0] msk);
        write_reg(SPARE_IDX_BASE + CFG_IDX_W'($urandom_range(0, 3)), CFG_W'($urandom));
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_HOLD, hld);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_REP_MASK, CFG_W'(msk));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic shuffle_config();
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] hld;
        logic [CFG_W-1:0] lim;
        case ($urandom_range(0, 9))
            0:       deb = '1;
            1:       deb = '0;
            default: deb = CFG_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       hld = '1;
            1:       hld = '0;
            default: hld = CFG_W'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 9))
            0:       lim = '1;
            1:       lim = '0;
            default: lim = CFG_W'($urandom_range(0, 5));
        endcase
        set_config(deb, hld, lim, KEY_FIELD_W'($urandom_range(0, 31)));
    endtask

    // mostly held chords with the odd bounce, some plain noise
    task automatic queue_presses(input int n);
        int                     made;
        int                     run;
        logic [KEY_FIELD_W-1:0] lv;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 9) < 8) begin
                lv  = KEY_FIELD_W'($urandom_range(0, 31));
                run = $urandom_range(1, 14);
                repeat (run) begin
                    if ($urandom_range(0, 7) == 0) begin
                        offer(lv ^ (KEY_FIELD_W'(1) << $urandom_range(0, KEYS - 1)));
                    end else begin
                        offer(lv);
                    end
                end
                made += run;
                run = $urandom_range(0, 2);
                repeat (run) offer('1);
                made += run;
            end else begin
                offer(KEY_FIELD_W'($urandom_range(0, 31)));
                made++;
            end
        end
    endtask

    // hold the sender until every tick is in and every event is out
    task automatic settle();
        do @(negedge i_clk);
        while (tick_accepts != ticks_queued || event_q.size() != 0);
    endtask

    // tick driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tick_taken) begin
            if (level_q.size() != 0 && (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_valid      <= 1'b1;
                i_key_levels <= level_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
        tick_taken = 1'b0;
    end

    // event receiver: random stalls plus requested long hold-offs
    always @(negedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : monitor
        logic [EVENT_W-1:0] want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                event_q.push_back(tick_event(i_key_levels));
                tick_accepts++;
                tick_taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                if (event_q.size() == 0) begin
                    flag_error($sformatf("event beat %0d with no tick pending", o_key_event));
                end else begin
                    want = event_q.pop_front();
                    if (o_key_event !== want) begin
                        flag_error($sformatf("key_event got %0d, want %0d", o_key_event, want));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int guard;
        for (int k = 0; k < KEYS; k++) begin
            held_lock[k] = 1'b0;
            press_cnt[k] = '0;
            rep_cnt[k]   = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values: nothing can be accepted this soon
        offer('1);
        offer('0);
        offer('0);
        offer('1);
        settle();

        // zero debounce and zero hold: accept on the first low tick, repeat on the next
        set_config('0, '0, '0, '1);
        offer(5'h1E);
        offer(5'h1E);
        offer(5'h1E);
        offer('0);
        offer('0);
        offer('1);
        offer(5'h0F);
        offer(5'h0F);
        settle();

        // keys 2, 4 and 5 without repeat stay silent once locked
        steady_run = 1'b1;
        set_config(CFG_W'(2), CFG_W'(1), CFG_W'(1), 5'h05);
        repeat (6) offer('0);
        repeat (3) offer(5'h15);
        offer('1);
        settle();
        steady_run = 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            shuffle_config();
            steady_run = (ph == 5);
            if (ph == 2) begin
                stall_request = 300;
            end
            if (ph == 4) begin
                queue_presses(30);
                settle();
                queue_presses(30);
            end else begin
                queue_presses(60);
            end
            settle();
        end
        steady_run = 1'b0;

        // longer debounce under the largest limit: key 5 is accepted once, never repeats
        set_config(CFG_W'(12), '0, '1, '1);
        repeat (30) offer({1'b0, 4'($urandom_range(0, 15))});
        offer('1);

        while (tick_accepts != ticks_queued) @(negedge i_clk);
        guard = 0;
        while (event_q.size() != 0 && guard < 4000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
        if (event_q.size() != 0) begin
            flag_error($sformatf("%0d tick events never arrived", event_q.size()));
        end
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
